// ----- hw/rtl/nld_pkg.sv -----
// ----------------------------------------------------------------------------
// nld_pkg
// Shared types and constants for the newline line deframer.
// ----------------------------------------------------------------------------
package nld_pkg;

	localparam int CFG_W              = 15;
	localparam int APB_ADDR_W         = 3;
	localparam int APB_DATA_W         = 32;
	localparam int LINE_LIMIT_MAX_DEF = 16 * 1024;

	localparam logic [CFG_W-1:0] MAX_LINE_RESET = CFG_W'(16 * 1024);

	localparam logic [7:0] LF_CODE = 8'h0A;
	localparam logic [7:0] CR_CODE = 8'h0D;

	// register index taken from the word address
	localparam logic REG_MAX_LINE_LENGTH = 1'b0;

	typedef struct packed {
		logic                  sel;
		logic                  enable;
		logic                  write;
		logic [APB_ADDR_W-1:0] addr;
		logic [APB_DATA_W-1:0] wdata;
	} apb_req_t;

endpackage

// ----- hw/rtl/nld_regs.sv -----
// ----------------------------------------------------------------------------
// nld_regs
// APB register file: holds the max_line_length limit, read back on prdata.
// ----------------------------------------------------------------------------
module nld_regs
	import nld_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  apb_req_t              req,
	output logic [APB_DATA_W-1:0] rdata,
	output logic [CFG_W-1:0]      max_line_length
);

	logic [CFG_W-1:0] limit_q;
	logic             reg_idx;
	logic             wr_en;

	// byte offset bits within the word are ignored
	assign reg_idx = req.addr[APB_ADDR_W-1];
	assign wr_en   = req.sel && req.enable && req.write && (reg_idx == REG_MAX_LINE_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= MAX_LINE_RESET;
		end else if (wr_en) begin
			limit_q <= req.wdata[CFG_W-1:0];
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_MAX_LINE_LENGTH: rdata = APB_DATA_W'(limit_q);
			default:             rdata = '0;
		endcase
	end

	assign max_line_length = limit_q;

endmodule

// ----- hw/rtl/newline_line_deframer.sv -----
// ----------------------------------------------------------------------------
// newline_line_deframer
// Cuts a byte stream into messages at each line feed, dropping a trailing
// carriage return, skipping empty lines and latching a line length overflow.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------
//  in        | sink      | in_valid / in_stall   | in_byte
//  out       | source    | out_valid / out_stall | out_byte, has_byte,
//            |           |                       | end_of_message, overflow_error
//  apb       | slave     | psel / penable        | paddr, pwdata, prdata
//
// One item per cycle unless stalled; the result is registered and shows in the next cycle.
// Each item yields zero or one result; the result register sits between the
// step logic and the output, so in_stall rises only while a result is held
// under out_stall. Reset clears the held byte, the count and the error; after
// an overflow the block keeps taking items and produces nothing until reset.
module newline_line_deframer
	import nld_pkg::*;
#(
	parameter int LINE_LIMIT_MAX = LINE_LIMIT_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            in_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            out_byte,
	output logic                  has_byte,
	output logic                  end_of_message,
	output logic                  overflow_error,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CNT_W = $clog2(LINE_LIMIT_MAX + 1);
	localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	apb_req_t         apb_req;
	logic [CFG_W-1:0] cfg_limit;

	assign apb_req = '{sel: psel, enable: penable, write: pwrite, addr: paddr, wdata: pwdata};
	assign pready  = 1'b1;

	nld_regs u_regs (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (apb_req),
		.rdata           (prdata),
		.max_line_length (cfg_limit)
	);

	// state
	logic [7:0]       held_byte_q;
	logic             held_valid_q;
	logic [CNT_W-1:0] sent_count_q;
	logic             error_q;

	// result register
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             has_byte_q;
	logic             end_q;
	logic             err_out_q;

	logic             in_accept;
	logic [LIM_W-1:0] limit_ext;
	logic [LIM_W-1:0] eff_limit;
	logic             over;
	logic             is_lf;

	logic             res_valid;
	logic [7:0]       res_byte;
	logic             res_has;
	logic             res_end;
	logic             res_err;
	logic             nxt_held_valid;
	logic [CNT_W-1:0] nxt_count;
	logic             nxt_error;

	assign in_stall  = out_valid_q && out_stall;
	assign in_accept = in_valid && !in_stall;

	assign limit_ext = LIM_W'(cfg_limit);

	always_comb begin
		priority if (cfg_limit == '0) begin
			eff_limit = LIM_W'(1);
		end else if (limit_ext > LIM_W'(LINE_LIMIT_MAX)) begin
			eff_limit = LIM_W'(LINE_LIMIT_MAX);
		end else begin
			eff_limit = limit_ext;
		end
	end

	// one more byte would pass the limit
	assign over  = LIM_W'(sent_count_q) >= eff_limit;
	assign is_lf = in_byte == LF_CODE;

	always_comb begin
		res_valid      = 1'b0;
		res_byte       = '0;
		res_has        = 1'b0;
		res_end        = 1'b0;
		res_err        = 1'b0;
		nxt_held_valid = held_valid_q;
		nxt_count      = sent_count_q;
		nxt_error      = error_q;
		if (!error_q) begin
			if (is_lf) begin
				nxt_held_valid = 1'b0;
				nxt_count      = '0;
				if (held_valid_q && held_byte_q != CR_CODE) begin
					res_valid = 1'b1;
					if (over) begin
						res_err   = 1'b1;
						nxt_error = 1'b1;
					end else begin
						res_byte = held_byte_q;
						res_has  = 1'b1;
						res_end  = 1'b1;
					end
				end else if (sent_count_q != '0) begin
					// CR LF after emitted bytes: end mark on its own
					res_valid = 1'b1;
					res_end   = 1'b1;
				end
			end else begin
				nxt_held_valid = 1'b1;
				if (held_valid_q) begin
					res_valid = 1'b1;
					if (over) begin
						res_err        = 1'b1;
						nxt_error      = 1'b1;
						nxt_held_valid = 1'b0;
					end else begin
						res_byte  = held_byte_q;
						res_has   = 1'b1;
						nxt_count = sent_count_q + CNT_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			sent_count_q <= '0;
			error_q      <= 1'b0;
		end else if (in_accept) begin
			held_valid_q <= nxt_held_valid;
			sent_count_q <= nxt_count;
			error_q      <= nxt_error;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q <= '0;
		end else if (in_accept && !error_q && !is_lf) begin
			held_byte_q <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= res_valid;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			out_byte_q <= res_byte;
			has_byte_q <= res_has;
			end_q      <= res_end;
			err_out_q  <= res_err;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign has_byte       = has_byte_q;
	assign end_of_message = end_q;
	assign overflow_error = err_out_q;

endmodule

// ----- hw/rtl/nld_checker.sv -----
// ----------------------------------------------------------------------------
// nld_checker
// Port-level checks on the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module nld_checker
	import nld_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       has_byte,
	input logic       end_of_message,
	input logic       overflow_error
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(has_byte)
			&& $stable(end_of_message) && $stable(overflow_error))
		else $error("stalled result changed");

	// the error item carries nothing else
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow_error |-> !has_byte && !end_of_message && out_byte == 8'h00)
		else $error("error item carries data");

	// an item without a byte is either an end mark or the error
	a_empty_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> (end_of_message != overflow_error) && out_byte == 8'h00)
		else $error("empty item without meaning");

	// nothing follows a delivered error
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && overflow_error |=> !out_valid)
		else $error("result after overflow");

	// input held back only by a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");

endmodule

bind newline_line_deframer nld_checker u_nld_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_stall       (in_stall),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.out_byte       (out_byte),
	.has_byte       (has_byte),
	.end_of_message (end_of_message),
	.overflow_error (overflow_error)
);
